### rtl/round_robin_task_scheduler_top_assert.svh
// Assertion macros used by the checker file of the scheduler.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_TOP_ASSERT_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define RRTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrts: assertion failed");

// Consequent checked in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrts: assertion failed");

`endif

### rtl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round robin task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  localparam int DEF_TASK_SLOTS = 8;

  localparam int CMD_W = 2;
  localparam int IDX_W = 4;
  localparam int CTX_W = 32;
  localparam int DLY_W = 32;

  localparam int IN_USER_W  = CMD_W + IDX_W;
  localparam int OUT_USER_W = IDX_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_DELAY  = 2'd1,
    CMD_SWITCH = 2'd2,
    CMD_SET    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    TS_READY   = 2'd0,
    TS_RUNNING = 2'd1,
    TS_WAITING = 2'd2
  } task_st_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic tick_step;
    logic search_step;
    logic commit;
    logic rd_en;
    logic out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_last;
    logic cand_ready;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/rrts_ctrl.sv
// ----------------------------------------------------------------------------
// rrts_ctrl
// Sequencer: accepts one word at a time and steps the datapath walks.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  rrts_pkg::cmd_e     command_i,
  input  rrts_pkg::dp_stat_t stat_i,
  output logic               s_tready_o,
  output rrts_pkg::dp_cmd_t  cmd_o
);
  import rrts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_SEARCH,
    S_READ,
    S_LOAD
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;
  logic   accept;

  assign accept     = s_tvalid_i & ready_q;
  assign s_tready_o = ready_q;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.accept = accept;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_TICK:   state_d = S_TICK;
            CMD_SWITCH: state_d = S_SEARCH;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_TICK: begin
        cmd_o.tick_step = 1'b1;
        if (stat_i.walk_last) state_d = S_IDLE;
      end
      S_SEARCH: begin
        // stop on the first ready slot or after a full lap
        if (stat_i.cand_ready || stat_i.walk_last) begin
          cmd_o.commit = 1'b1;
          state_d      = S_READ;
        end else begin
          cmd_o.search_step = 1'b1;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_LOAD;
      end
      S_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == S_IDLE);
    end
  end

endmodule

`default_nettype wire

### rtl/rrts_dp.sv
// ----------------------------------------------------------------------------
// rrts_dp
// Task table, delay counters, context memory and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_dp #(
  parameter int TaskSlots = rrts_pkg::DEF_TASK_SLOTS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rrts_pkg::dp_cmd_t          cmd_i,
  input  rrts_pkg::cmd_e             command_i,
  input  logic [rrts_pkg::IDX_W-1:0] task_index_i,
  input  logic [rrts_pkg::CTX_W-1:0] operand_i,
  input  logic                       m_tready_i,
  output rrts_pkg::dp_stat_t         stat_o,
  output logic                       m_tvalid_o,
  output logic [rrts_pkg::CTX_W-1:0] next_context_o,
  output logic [rrts_pkg::IDX_W-1:0] selected_task_o,
  output logic                       idle_selected_o
);
  import rrts_pkg::*;

  // slot number including the idle code, and plain table index
  localparam int SlotW = $clog2(TaskSlots + 1);
  localparam int WalkW = (TaskSlots > 1) ? $clog2(TaskSlots) : 1;
  localparam int ExtW  = IDX_W + SlotW;

  localparam logic [SlotW-1:0] IdleCode = SlotW'(TaskSlots);
  localparam logic [WalkW-1:0] LastIdx  = WalkW'(TaskSlots - 1);

  task_st_e          status_q [TaskSlots];
  logic [DLY_W-1:0]  cnt_q    [TaskSlots];
  logic [CTX_W-1:0]  ctx_mem  [TaskSlots+1];

  logic [SlotW-1:0]  cur_q;
  logic              cur_run_q;   // current slot holds running status
  logic [WalkW-1:0]  walk_q;
  logic [WalkW-1:0]  step_q;
  logic [CTX_W-1:0]  rd_q;

  logic              out_valid_q;
  logic [CTX_W-1:0]  out_ctx_q;
  logic [IDX_W-1:0]  out_sel_q;
  logic              out_idle_q;

  logic              cur_idle;
  logic [WalkW-1:0]  cur_lo;
  logic [WalkW-1:0]  walk_nxt;
  logic [WalkW-1:0]  start;
  task_st_e          walk_st;
  logic [DLY_W-1:0]  walk_cnt;
  logic [ExtW-1:0]   idx_ext;
  logic              set_ok;
  logic [SlotW-1:0]  set_addr;
  logic [ExtW-1:0]   sel_ext;

  assign cur_idle = (cur_q == IdleCode);
  assign cur_lo   = cur_q[WalkW-1:0];
  assign walk_nxt = (walk_q == LastIdx) ? '0 : walk_q + 1'b1;
  assign start    = (cur_idle || cur_lo == LastIdx) ? '0 : cur_lo + 1'b1;
  assign walk_st  = status_q[walk_q];
  assign walk_cnt = cnt_q[walk_q];

  assign idx_ext  = {{SlotW{1'b0}}, task_index_i};
  assign set_ok   = (idx_ext <= ExtW'(TaskSlots));
  assign set_addr = idx_ext[SlotW-1:0];
  assign sel_ext  = {{IDX_W{1'b0}}, cur_q};

  assign stat_o.walk_last  = (step_q == LastIdx);
  assign stat_o.cand_ready = (walk_st == TS_READY);
  assign stat_o.out_free   = !out_valid_q || m_tready_i;

  // task table and current slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TaskSlots; i++) begin
        status_q[i] <= TS_READY;
        cnt_q[i]    <= '0;
      end
      cur_q     <= IdleCode;
      cur_run_q <= 1'b0;
    end else begin
      if (cmd_i.accept && command_i == CMD_DELAY && !cur_idle) begin
        status_q[cur_lo] <= TS_WAITING;
        cnt_q[cur_lo]    <= operand_i;
        cur_run_q        <= 1'b0;
      end
      // a zero count never expires
      if (cmd_i.tick_step && walk_st == TS_WAITING && walk_cnt != '0) begin
        cnt_q[walk_q] <= walk_cnt - 1'b1;
        if (walk_cnt == DLY_W'(1)) status_q[walk_q] <= TS_READY;
      end
      if (cmd_i.commit) begin
        if (walk_st == TS_READY) begin
          if (cur_run_q) status_q[cur_lo] <= TS_READY;
          status_q[walk_q] <= TS_RUNNING;
          cur_q            <= SlotW'(walk_q);
          cur_run_q        <= 1'b1;
        end else if (!cur_run_q) begin
          cur_q <= IdleCode;
        end
      end
    end
  end

  // slot walk shared by tick and search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '0;
      step_q <= '0;
    end else if (cmd_i.accept) begin
      walk_q <= (command_i == CMD_SWITCH) ? start : '0;
      step_q <= '0;
    end else if (cmd_i.tick_step || cmd_i.search_step) begin
      walk_q <= walk_nxt;
      step_q <= step_q + 1'b1;
    end
  end

  // context memory; idle context sits at the idle code address
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (command_i == CMD_SWITCH) begin
        ctx_mem[cur_q] <= operand_i;
      end else if (command_i == CMD_SET && set_ok) begin
        ctx_mem[set_addr] <= operand_i;
      end
    end
    if (cmd_i.rd_en) rd_q <= ctx_mem[cur_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_ctx_q  <= rd_q;
      out_sel_q  <= sel_ext[IDX_W-1:0];
      out_idle_q <= cur_idle;
    end
  end

  assign m_tvalid_o      = out_valid_q;
  assign next_context_o  = out_ctx_q;
  assign selected_task_o = out_sel_q;
  assign idle_selected_o = out_idle_q;

endmodule

`default_nettype wire

### rtl/round_robin_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_top
// Round robin task scheduler with per-task delay counters.
//
//   channel  dir  tdata               tuser
//   s_*      in   operand_value[31:0] command[1:0], task_index[5:2]
//   m_*      out  next_context[31:0]  selected_task[3:0], idle_selected[4]
//
// Delay and set-context words finish as they are accepted; a tick and a switch
// walk the task table at one slot per cycle, and a switch ends in one
// registered context memory read.
// One word is in work at a time; a finished result waits in the output
// register and a new word is accepted while it waits.
// Reset clears the task table and the current slot at once; the context
// memory is not cleared and needs no pass.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_scheduler_top #(
  parameter int TaskSlots = rrts_pkg::DEF_TASK_SLOTS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [rrts_pkg::CTX_W-1:0]      s_tdata_i,  // operand_value
  input  logic [rrts_pkg::IN_USER_W-1:0]  s_tuser_i,  // command, task_index
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [rrts_pkg::CTX_W-1:0]      m_tdata_o,  // next_context
  output logic [rrts_pkg::OUT_USER_W-1:0] m_tuser_o   // selected_task, idle_selected
);
  import rrts_pkg::*;

  dp_cmd_t          dp_cmd;
  dp_stat_t         dp_stat;
  cmd_e             command;
  logic [IDX_W-1:0] task_index;
  logic [IDX_W-1:0] selected_task;
  logic             idle_selected;

  assign command    = cmd_e'(s_tuser_i[CMD_W-1:0]);
  assign task_index = s_tuser_i[CMD_W +: IDX_W];

  rrts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .command_i  (command),
    .stat_i     (dp_stat),
    .s_tready_o (s_tready_o),
    .cmd_o      (dp_cmd)
  );

  rrts_dp #(
    .TaskSlots (TaskSlots)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .command_i       (command),
    .task_index_i    (task_index),
    .operand_i       (s_tdata_i),
    .m_tready_i      (m_tready_i),
    .stat_o          (dp_stat),
    .m_tvalid_o      (m_tvalid_o),
    .next_context_o  (m_tdata_o),
    .selected_task_o (selected_task),
    .idle_selected_o (idle_selected)
  );

  assign m_tuser_o = {idle_selected, selected_task};

endmodule

`default_nettype wire

### rtl/rrts_checker.sv
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "round_robin_task_scheduler_top_assert.svh"

module rrts_checker #(
  parameter int TaskSlots = rrts_pkg::DEF_TASK_SLOTS
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_tvalid_i,
  input logic                            s_tready_o,
  input logic [rrts_pkg::CTX_W-1:0]      s_tdata_i,
  input logic [rrts_pkg::IN_USER_W-1:0]  s_tuser_i,
  input logic                            m_tvalid_o,
  input logic                            m_tready_i,
  input logic [rrts_pkg::CTX_W-1:0]      m_tdata_o,
  input logic [rrts_pkg::OUT_USER_W-1:0] m_tuser_o
);
  import rrts_pkg::*;

  localparam logic [IDX_W-1:0] IdleSel = IDX_W'(TaskSlots);

  logic s_acc;
  logic unused_data;

  assign s_acc       = s_tvalid_i && s_tready_o;
  assign unused_data = ^s_tdata_i;

  // stalled result word holds
  `RRTS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid_o && !m_tready_i, m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o))

  // idle flag agrees with the idle slot code
  `RRTS_ASSERT_IMPL(a_idle_flag, clk_i, rst_ni, m_tvalid_o, m_tuser_o[IDX_W] == (m_tuser_o[IDX_W-1:0] == IdleSel))

  // a tick walks the table, so the input side closes right after it
  `RRTS_ASSERT_NEXT(a_tick_busy, clk_i, rst_ni, s_acc && s_tuser_i[CMD_W-1:0] == CMD_TICK, !s_tready_o)

  // a result only appears at the end of a busy phase
  `RRTS_ASSERT_IMPL(a_out_from_busy, clk_i, rst_ni, $rose(m_tvalid_o), !$past(s_tready_o))

endmodule

bind round_robin_task_scheduler_top rrts_checker #(
  .TaskSlots (TaskSlots)
) u_rrts_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .s_tdata_i  (s_tdata_i),
  .s_tuser_i  (s_tuser_i),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o)
);

`default_nettype wire

### tb/sv/round_robin_task_scheduler_top_tb.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_top_tb
// Self-checking bench for the round robin task scheduler. Words go in on the
// s_* stream; a scoreboard process tracks the task table, delay counters and
// context store, queues the expected result for each accepted switch word
// and compares every word taken off the m_* stream against it.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_scheduler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrts_pkg::*;

  localparam int TASK_SLOTS  = DEF_TASK_SLOTS;
  localparam int IDLE_SLOT   = TASK_SLOTS;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYC  = 2 * (TASK_SLOTS + 4);

  typedef struct packed {
    logic [CTX_W-1:0] ctx;
    logic [IDX_W-1:0] slot;
    logic             idle;
  } sched_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_tvalid_i;
  logic                  s_tready_o;
  logic [CTX_W-1:0]      s_tdata_i;   // operand_value
  logic [IN_USER_W-1:0]  s_tuser_i;   // command[1:0], task_index[5:2]
  logic                  m_tvalid_o;
  logic                  m_tready_i;
  logic [CTX_W-1:0]      m_tdata_o;   // next_context
  logic [OUT_USER_W-1:0] m_tuser_o;   // selected_task[3:0], idle_selected[4]

  // scheduler shadow state
  task_st_e         tsk_state [TASK_SLOTS];
  logic [DLY_W-1:0] dly_cnt   [TASK_SLOTS];
  logic [CTX_W-1:0] ctx_mem   [TASK_SLOTS+1];
  int               cur_slot;

  sched_result_t sched_expect_q[$];
  sched_result_t want_res;

  int errors;
  int quiet_cycles;
  int hold_cycles;
  int stall_cycles;
  bit idle_en;

  round_robin_task_scheduler_top #(
    .TaskSlots(TASK_SLOTS)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .s_tuser_i (s_tuser_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .m_tuser_o (m_tuser_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Apply one accepted word to the shadow state; a switch queues its result.
  task automatic schedule_word(input cmd_e cmd, input logic [IDX_W-1:0] idx,
                               input logic [CTX_W-1:0] val);
    int prev;
    int start;
    int cand;
    bit found;
    sched_result_t res;
    case (cmd)
      CMD_TICK: begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (tsk_state[i] == TS_WAITING && dly_cnt[i] != '0) begin
            dly_cnt[i] = dly_cnt[i] - 1'b1;
            if (dly_cnt[i] == '0) tsk_state[i] = TS_READY;
          end
        end
      end
      CMD_DELAY: begin
        if (cur_slot < IDLE_SLOT) begin
          tsk_state[cur_slot] = TS_WAITING;
          dly_cnt[cur_slot]   = val;
        end
      end
      CMD_SWITCH: begin
        prev = cur_slot;
        if (prev >= IDLE_SLOT) begin
          ctx_mem[IDLE_SLOT] = val;
          start = 0;
        end else begin
          ctx_mem[prev] = val;
          start = (prev + 1) % TASK_SLOTS;
        end
        found = 1'b0;
        cand  = start;
        for (int k = 0; k < TASK_SLOTS && !found; k++) begin
          if (tsk_state[cand] == TS_READY) found = 1'b1;
          else cand = (cand + 1) % TASK_SLOTS;
        end
        if (found) begin
          if (prev < IDLE_SLOT && prev != cand && tsk_state[prev] == TS_RUNNING)
            tsk_state[prev] = TS_READY;
          tsk_state[cand] = TS_RUNNING;
          cur_slot = cand;
        end else if (!(prev < IDLE_SLOT && tsk_state[prev] == TS_RUNNING)) begin
          cur_slot = IDLE_SLOT;
        end
        res.ctx  = ctx_mem[cur_slot];
        res.slot = cur_slot[IDX_W-1:0];
        res.idle = (cur_slot == IDLE_SLOT);
        sched_expect_q.push_back(res);
      end
      default: begin
        if (idx <= IDLE_SLOT) ctx_mem[idx] = val;
      end
    endcase
  endtask

  // Offer one word, wait for the handshake, then update the shadow state.
  task automatic send_word(input cmd_e cmd, input logic [IDX_W-1:0] idx,
                           input logic [CTX_W-1:0] val);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= val;
    s_tuser_i  <= {idx, cmd};
    do @(posedge clk_i); while (!s_tready_o);
    schedule_word(cmd, idx, val);
  endtask

  // Mostly short delays so tasks keep cycling through waiting and ready;
  // counts that never run out only when allowed.
  task automatic send_random_word(input bit allow_forever);
    int sel;
    logic [CTX_W-1:0] val;
    cmd_e cmd;
    sel = $urandom_range(0, 99);
    val = $urandom;
    if (sel < 35) begin
      cmd = CMD_SWITCH;
    end else if (sel < 65) begin
      cmd = CMD_DELAY;
      sel = $urandom_range(0, 19);
      if (allow_forever && sel == 0) val = '0;
      else if (allow_forever && sel == 1) val = val | 32'h8000_0000;
      else if (sel < 15) val = $urandom_range(1, 5);
      else val = $urandom_range(6, 16);
    end else if (sel < 90) begin
      cmd = CMD_TICK;
    end else begin
      cmd = CMD_SET;
    end
    send_word(cmd, IDX_W'($urandom_range(0, 15)), val);
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
  endtask

  // Every context entry written before any switch can read it; indexes past
  // the idle entry must be ignored.
  task automatic test_context_load();
    for (int i = 0; i <= IDLE_SLOT; i++) begin
      if (i == 0) send_word(CMD_SET, IDX_W'(i), '0);
      else if (i == 1) send_word(CMD_SET, IDX_W'(i), '1);
      else send_word(CMD_SET, IDX_W'(i), $urandom);
    end
    send_word(CMD_SET, 4'd15, '1);
    send_word(CMD_SET, 4'd9, '0);
  endtask

  task automatic test_delay_and_switch();
    send_word(CMD_DELAY, 4'd0, 32'd5);   // idle: no current task to delay
    send_word(CMD_TICK, 4'd15, '1);
    send_word(CMD_SWITCH, 4'd0, '1);     // idle -> slot 0
    send_word(CMD_DELAY, 4'd3, '0);      // slot 0 waits forever
    send_word(CMD_SWITCH, 4'd0, '0);     // -> slot 1
    send_word(CMD_DELAY, 4'd0, 32'd1);
    send_word(CMD_TICK, 4'd0, '0);       // slot 1 ready again, slot 0 untouched
    send_word(CMD_DELAY, 4'd0, '1);      // slot 1 waits for the max count
    send_word(CMD_SWITCH, 4'd0, $urandom);
    send_word(CMD_SWITCH, 4'd8, $urandom);
    send_word(CMD_TICK, 4'd0, $urandom);
  endtask

  // Long receiver hold-off while words keep coming, so the input stalls.
  task automatic test_result_backpressure();
    @(posedge clk_i);
    hold_cycles = 150;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 2) send_word(CMD_TICK, IDX_W'($urandom_range(0, 15)), $urandom);
      else send_word(CMD_SWITCH, IDX_W'($urandom_range(0, 15)), $urandom);
    end
  endtask

  // Sender pauses until every pending result has drained.
  task automatic test_drain_pause();
    for (int i = 0; i < 15; i++) send_random_word(1'b0);
    drop_valid();
    while (sched_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    for (int i = 0; i < 15; i++) send_random_word(1'b0);
  endtask

  task automatic test_random_mix(input int count, input bit allow_forever);
    for (int i = 0; i < count; i++) send_random_word(allow_forever);
  endtask

  // receiver: short random stall bursts, plus a requested long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      m_tready_i <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else if (stall_cycles != 0) begin
      m_tready_i <= 1'b0;
      stall_cycles = stall_cycles - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      m_tready_i <= 1'b0;
      stall_cycles = $urandom_range(0, 3);
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (sched_expect_q.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10)
          $display("unexpected word: ctx=%h user=%h", m_tdata_o, m_tuser_o);
      end else begin
        want_res = sched_expect_q.pop_front();
        if (m_tdata_o !== want_res.ctx || m_tuser_o[IDX_W-1:0] !== want_res.slot ||
            m_tuser_o[IDX_W] !== want_res.idle) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("mismatch: ctx exp %h got %h, task exp %0d got %0d, idle exp %b got %b",
                     want_res.ctx, m_tdata_o, want_res.slot, m_tuser_o[IDX_W-1:0],
                     want_res.idle, m_tuser_o[IDX_W]);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    s_tvalid_i   = 1'b0;
    s_tdata_i    = '0;
    s_tuser_i    = '0;
    m_tready_i   = 1'b0;
    errors       = 0;
    quiet_cycles = 0;
    hold_cycles  = 0;
    stall_cycles = 0;
    idle_en      = 1'b1;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      tsk_state[i] = TS_READY;
      dly_cnt[i]   = '0;
    end
    for (int i = 0; i <= TASK_SLOTS; i++) ctx_mem[i] = '0;
    cur_slot = IDLE_SLOT;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_context_load();
    test_delay_and_switch();
    test_result_backpressure();
    test_drain_pause();
    test_random_mix(900, 1'b0);
    idle_en = 1'b0;
    test_random_mix(450, 1'b1);

    drop_valid();
    while (sched_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    errors = errors + sched_expect_q.size();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+rtl
rtl/rrts_pkg.sv
rtl/rrts_ctrl.sv
rtl/rrts_dp.sv
rtl/round_robin_task_scheduler_top.sv
rtl/rrts_checker.sv
tb/sv/round_robin_task_scheduler_top_tb.sv
